// ===== hw/rtl/hts_pkg.sv =====
`default_nettype none
package hts_pkg;

  typedef enum logic [1:0] {
    MODE_COPY   = 2'd0,
    MODE_TAG    = 2'd1,
    MODE_ENTITY = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_text;
  } result_t;

  localparam int QDepth = 2;
  localparam int QIdxW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [31:0] TAG_BR     = 32'h0000_7262;
  localparam logic [31:0] TAG_BR_SL  = 32'h002f_7262;
  localparam logic [31:0] TAG_DIV_CL = 32'h7669_642f;
  localparam logic [15:0] TAG_TR     = 16'h7274;
  localparam logic [15:0] TAG_TD     = 16'h6474;
  localparam logic [23:0] ENT_LT     = 24'h00_746c;
  localparam logic [23:0] ENT_GT     = 24'h00_7467;
  localparam logic [23:0] ENT_AMP    = 24'h70_6d61;

  localparam logic [2:0] TAG_SAT = 3'd5;
  localparam logic [2:0] ENT_SAT = 3'd4;

endpackage
`default_nettype wire

// ===== hw/rtl/hts_in_if.sv =====
`default_nettype none
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hts_out_if.sv =====
`default_nettype none
interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output has_char, output end_of_text,
                  input ready);
  modport sink (input valid, input out_char, input has_char, input end_of_text,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hts_front.sv =====
`default_nettype none
module hts_front (
  input  wire logic            clk,
  input  wire logic            rst,
  hts_in_if.sink               din,
  input  wire logic            q_full,
  output logic                 push,
  output hts_pkg::result_t     push_data
);
  import hts_pkg::*;

  mode_t       mode, mode_next;
  logic [31:0] tag_prefix, tag_prefix_next;
  logic [2:0]  tag_count, tag_count_next;
  logic [23:0] entity_prefix, entity_prefix_next;
  logic [2:0]  entity_count, entity_count_next;

  logic       accept;
  logic [7:0] c;
  logic [7:0] tag_char;
  logic [7:0] ent_char;
  logic       spaced;
  logic       give;
  logic [7:0] ch;

  assign din.ready = !q_full;
  assign accept    = din.valid && din.ready;
  assign c         = din.in_char;

  // tag and entity classification
  assign spaced = (tag_count >= 3'd3) && (tag_prefix[23:16] == CH_SPACE);

  always_comb begin
    tag_char = 8'd0;
    if (tag_count == 3'd2 && tag_prefix == TAG_BR) begin
      tag_char = CH_NL;
    end else if (tag_count == 3'd3 && tag_prefix == TAG_BR_SL) begin
      tag_char = CH_NL;
    end else if (tag_count == 3'd4 && tag_prefix == TAG_DIV_CL) begin
      tag_char = CH_NL;
    end else if (tag_prefix[15:0] == TAG_TR && (tag_count == 3'd2 || spaced)) begin
      tag_char = CH_NL;
    end else if (tag_prefix[15:0] == TAG_TD && (tag_count == 3'd2 || spaced)) begin
      tag_char = CH_TAB;
    end
  end

  always_comb begin
    ent_char = 8'd0;
    if (entity_count == 3'd2 && entity_prefix == ENT_LT) begin
      ent_char = CH_LT;
    end else if (entity_count == 3'd2 && entity_prefix == ENT_GT) begin
      ent_char = CH_GT;
    end else if (entity_count == 3'd3 && entity_prefix == ENT_AMP) begin
      ent_char = CH_AMP;
    end
  end

  // next state
  always_comb begin
    mode_next          = mode;
    tag_prefix_next    = tag_prefix;
    tag_count_next     = tag_count;
    entity_prefix_next = entity_prefix;
    entity_count_next  = entity_count;
    if (accept) begin
      if (c == CH_LT) begin
        mode_next       = MODE_TAG;
        tag_prefix_next = '0;
        tag_count_next  = '0;
      end else if (mode == MODE_TAG) begin
        if (c == CH_GT) begin
          mode_next = MODE_COPY;
        end else begin
          case (tag_count)
            3'd0:    tag_prefix_next[7:0]   = c;
            3'd1:    tag_prefix_next[15:8]  = c;
            3'd2:    tag_prefix_next[23:16] = c;
            3'd3:    tag_prefix_next[31:24] = c;
            default: tag_prefix_next        = tag_prefix;
          endcase
          if (tag_count < TAG_SAT) begin
            tag_count_next = tag_count + 3'd1;
          end
        end
      end else if (c == CH_GT) begin
        mode_next = MODE_COPY;
      end else if (c == CH_AMP) begin
        mode_next          = MODE_ENTITY;
        entity_prefix_next = '0;
        entity_count_next  = '0;
      end else if (mode == MODE_ENTITY) begin
        if (c == CH_SEMI) begin
          mode_next = (ent_char != 8'd0) ? MODE_COPY : MODE_DROP;
        end else begin
          case (entity_count)
            3'd0:    entity_prefix_next[7:0]   = c;
            3'd1:    entity_prefix_next[15:8]  = c;
            3'd2:    entity_prefix_next[23:16] = c;
            default: entity_prefix_next        = entity_prefix;
          endcase
          if (entity_count < ENT_SAT) begin
            entity_count_next = entity_count + 3'd1;
          end
        end
      end
      if (din.in_last) begin
        mode_next          = MODE_COPY;
        tag_prefix_next    = '0;
        tag_count_next     = '0;
        entity_prefix_next = '0;
        entity_count_next  = '0;
      end
    end
  end

  // outputs
  always_comb begin
    give = 1'b0;
    ch   = 8'd0;
    if (c != CH_LT) begin
      case (mode)
        MODE_TAG: begin
          if (c == CH_GT) begin
            ch   = tag_char;
            give = tag_char != 8'd0;
          end
        end
        MODE_ENTITY: begin
          if (c == CH_SEMI) begin
            ch   = ent_char;
            give = ent_char != 8'd0;
          end
        end
        MODE_COPY: begin
          if (c != CH_GT && c != CH_AMP) begin
            ch   = c;
            give = 1'b1;
          end
        end
        default: begin
          give = 1'b0;
          ch   = 8'd0;
        end
      endcase
    end
  end

  assign push                  = accept && (give || din.in_last);
  assign push_data.out_char    = give ? ch : 8'd0;
  assign push_data.has_char    = give;
  assign push_data.end_of_text = din.in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_COPY;
      tag_prefix    <= '0;
      tag_count     <= '0;
      entity_prefix <= '0;
      entity_count  <= '0;
    end else begin
      mode          <= mode_next;
      tag_prefix    <= tag_prefix_next;
      tag_count     <= tag_count_next;
      entity_prefix <= entity_prefix_next;
      entity_count  <= entity_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hts_queue.sv =====
`default_nettype none
module hts_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire hts_pkg::result_t push_data,
  input  wire logic             pop,
  output hts_pkg::result_t      pop_data,
  output hts_pkg::q_stat_t      stat
);
  import hts_pkg::*;

  result_t          entries [QDepth];
  logic [QIdxW-1:0] wptr;
  logic [QIdxW-1:0] rptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.count = count;
  assign stat.full  = count == QCntW'(QDepth);
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QIdxW'(QDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QIdxW'(QDepth - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hts_back.sv =====
`default_nettype none
module hts_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hts_pkg::result_t q_data,
  input  wire logic             q_empty,
  output logic                  pop,
  hts_out_if.source             dout
);
  import hts_pkg::*;

  logic    valid;
  result_t data;

  assign pop              = !q_empty && (!valid || dout.ready);
  assign dout.valid       = valid;
  assign dout.out_char    = data.out_char;
  assign dout.has_char    = data.has_char;
  assign dout.end_of_text = data.end_of_text;

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/html_tag_stripper_core.sv =====
// markup-to-plain-text filter, one byte per request on din
// din carries in_char and in_last; dout carries out_char, has_char and end_of_text
// plain bytes are copied, tags and entities are parsed and dropped or translated
// (br, br/, /div, tr give a newline, td gives a tab, lt/gt/amp give their char)
// each input byte gives zero or one result; the last byte always gives one result,
// a bare end marker with has_char low if the byte itself yields no character
// the front parses a byte as it is accepted, writing its result to the queue
// throughput: one byte per cycle while the queue is not full
// a two-entry queue sits between the parser and the output register
// when dout stalls the queue fills and din.ready drops once it is full;
// no result is lost or repeated
// reset (rst, synchronous) clears the parser to copy mode and empties the queue
// and output register; after a last byte the parser returns to its reset state
`default_nettype none
module html_tag_stripper_core (
  input  wire logic clk,
  input  wire logic rst,
  hts_in_if.sink    din,
  hts_out_if.source dout
);
  import hts_pkg::*;

  logic    push;
  result_t push_data;
  logic    pop;
  result_t pop_data;
  q_stat_t qstat;

  hts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .q_full    (qstat.full),
    .push      (push),
    .push_data (push_data)
  );

  hts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  hts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (pop_data),
    .q_empty (qstat.empty),
    .pop     (pop),
    .dout    (dout)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCntW'(QDepth))
    else $error("queue count out of range");

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.in_last) |-> (push && push_data.end_of_text))
    else $error("last byte gave no end marker");

  a_eot_from_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.end_of_text) |-> din.in_last)
    else $error("end marker without last byte");

endmodule
`default_nettype wire
